/* rtl/tcr_pkg.sv */
// Shared widths and the front-to-back work item of the triangle circumradius block.
// No dependencies; imported by every module in rtl/.
`timescale 1ns / 1ps

package tcr_pkg;

  localparam int COORD_W  = 24;              // vertex coordinate, signed Q12.12
  localparam int NUM_COORD = 9;
  localparam int IN_W     = COORD_W * NUM_COORD;
  localparam int EDGE_W   = COORD_W + 1;     // edge vector component
  localparam int HALF_W   = EDGE_W;          // operand slice for split multiplies
  localparam int SQ_W     = 2 * EDGE_W;      // one 25x25 product
  localparam int LEN_W    = SQ_W;            // squared edge length
  localparam int DIFF_W   = SQ_W + 1;        // cross product component, signed
  localparam int DMAG_W   = SQ_W;            // its magnitude
  localparam int K_W      = 2 * DMAG_W + 2;  // |e1 x e2|^2
  localparam int P_W      = 2 * LEN_W;       // A2*B2
  localparam int DEN_W    = K_W + 2;         // 4*|e1 x e2|^2
  localparam int NUM_W    = P_W + LEN_W;     // A2*B2*C2
  localparam int RAD_W    = 36;              // radius, unsigned Q24.12
  localparam int Q_W      = 2 * RAD_W;       // radius squared quotient
  localparam int OUT_DATA_W = 40;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W   = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             degenerate;
  } tcr_work_t;

endpackage

/* rtl/triangle_circumradius_top.sv */
// Top level of the 3D triangle circumradius block (Heron form, exact integer math).
// Depends on tcr_pkg, tcr_front, tcr_queue, tcr_back.
//
// Usage:
//   in_*  : one transfer carries one triangle, nine signed Q12.12 coordinates.
//   out_* : one transfer per triangle, in order: radius (unsigned Q24.12,
//           floor of the true value) plus degenerate/saturated flags.
//   Throughput: one triangle per cycle sustained while out_tready stays high.
//   Pipeline: the front registers edges, products and num/den, then the queue;
//   the back has a range check, one quotient bit per stage of R^2 and one root
//   bit per stage, with a register before the root stages and at the output.
//   The front stalls only when the 4-entry queue is full; the back stalls
//   only when the output register holds a transfer the receiver has not taken,
//   so each side runs while the other waits.
//   Degenerate triangles (collinear or coincident vertices) give radius 0 with
//   degenerate set; a radius of 2^24 or more gives all ones with saturated set.
//   Reset (rst_n low, synchronous) empties both pipelines and the queue; items
//   in flight are dropped. There is no configuration.
`timescale 1ns / 1ps

module triangle_circumradius_top
  import tcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z (24 bits each)
  input  logic [IN_W-1:0]       in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // radius [35:0], zero pad [39:36]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // degenerate [0], saturated [1]
  output logic [1:0]            out_tuser
);

  logic             f_valid, f_ready;
  tcr_work_t        f_work;
  logic             b_valid, b_ready;
  tcr_work_t        b_work;
  logic [RAD_W-1:0] radius;
  logic             degenerate, saturated;

  tcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_work  (f_work)
  );

  tcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_work   (f_work),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_work  (b_work)
  );

  tcr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (b_valid),
    .in_ready       (b_ready),
    .in_work        (b_work),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_radius     (radius),
    .out_degenerate (degenerate),
    .out_saturated  (saturated)
  );

  assign out_tdata = {{(OUT_DATA_W-RAD_W){1'b0}}, radius};
  assign out_tuser = {saturated, degenerate};

endmodule

/* rtl/tcr_front.sv */
// Front pipeline: edge vectors, squared lengths, cross product and the exact
// numerator/denominator of R^2. Depends on tcr_pkg.
`timescale 1ns / 1ps

module tcr_front
  import tcr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IN_W-1:0]  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tcr_work_t        out_work
);

  localparam int NSTG = 7;

  logic                     en;
  logic [NSTG-1:0]          v_r;

  logic signed [EDGE_W-1:0] e_nxt [3][3];
  logic signed [EDGE_W-1:0] e_r   [3][3];
  logic [SQ_W-1:0]          sq_r  [3][3];
  logic signed [SQ_W-1:0]   cr_r  [6];
  logic [LEN_W-1:0]         len_r [3];
  logic [DMAG_W-1:0]        dm_r  [3];
  logic [SQ_W-1:0]          dpp_r [3][3];
  logic [SQ_W-1:0]          abpp_r [4];
  logic [LEN_W-1:0]         c2_3_r, c2_4_r;
  logic [K_W-1:0]           k4_r, k5_r;
  logic [P_W-1:0]           p4_r;
  logic [SQ_W-1:0]          pp_r [4][2];
  logic                     deg5_r, deg6_r;
  logic [NUM_W-1:0]         num6_r;
  logic [DEN_W-1:0]         den6_r;

  assign en        = !(v_r[NSTG-1] && !out_ready);
  assign in_ready  = en;
  assign out_valid = v_r[NSTG-1];
  assign out_work  = '{num: num6_r, den: den6_r, degenerate: deg6_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  // edges: e1 = p2 - p1, e2 = p3 - p1, e3 = p3 - p2
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      e_nxt[0][c] = $signed({in_data[(3+c)*COORD_W+COORD_W-1], in_data[(3+c)*COORD_W +: COORD_W]})
                  - $signed({in_data[c*COORD_W+COORD_W-1], in_data[c*COORD_W +: COORD_W]});
      e_nxt[1][c] = $signed({in_data[(6+c)*COORD_W+COORD_W-1], in_data[(6+c)*COORD_W +: COORD_W]})
                  - $signed({in_data[c*COORD_W+COORD_W-1], in_data[c*COORD_W +: COORD_W]});
      e_nxt[2][c] = $signed({in_data[(6+c)*COORD_W+COORD_W-1], in_data[(6+c)*COORD_W +: COORD_W]})
                  - $signed({in_data[(3+c)*COORD_W+COORD_W-1], in_data[(3+c)*COORD_W +: COORD_W]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r <= e_nxt;
      // squares and cross terms
      for (int j = 0; j < 3; j++) begin
        for (int c = 0; c < 3; c++) begin
          sq_r[j][c] <= SQ_W'(e_r[j][c] * e_r[j][c]);
        end
      end
      cr_r[0] <= e_r[0][1] * e_r[1][2];
      cr_r[1] <= e_r[0][2] * e_r[1][1];
      cr_r[2] <= e_r[0][2] * e_r[1][0];
      cr_r[3] <= e_r[0][0] * e_r[1][2];
      cr_r[4] <= e_r[0][0] * e_r[1][1];
      cr_r[5] <= e_r[0][1] * e_r[1][0];
    end
  end

  always_ff @(posedge clk) begin
    logic signed [DIFF_W-1:0] d;
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        len_r[j] <= sq_r[j][0] + sq_r[j][1] + sq_r[j][2];
      end
      for (int m = 0; m < 3; m++) begin
        d = $signed({cr_r[2*m][SQ_W-1], cr_r[2*m]})
          - $signed({cr_r[2*m+1][SQ_W-1], cr_r[2*m+1]});
        dm_r[m] <= d[DIFF_W-1] ? DMAG_W'(-d) : DMAG_W'(d);
      end
    end
  end

  // split 50x50 multiplies into 25x25 partial products
  always_ff @(posedge clk) begin
    logic [SQ_W-1:0] hi, lo, ahi, alo, bhi, blo;
    if (en) begin
      for (int m = 0; m < 3; m++) begin
        hi = SQ_W'(dm_r[m][DMAG_W-1:HALF_W]);
        lo = SQ_W'(dm_r[m][HALF_W-1:0]);
        dpp_r[m][0] <= hi * hi;
        dpp_r[m][1] <= hi * lo;
        dpp_r[m][2] <= lo * lo;
      end
      ahi = SQ_W'(len_r[0][LEN_W-1:HALF_W]);
      alo = SQ_W'(len_r[0][HALF_W-1:0]);
      bhi = SQ_W'(len_r[1][LEN_W-1:HALF_W]);
      blo = SQ_W'(len_r[1][HALF_W-1:0]);
      abpp_r[0] <= ahi * bhi;
      abpp_r[1] <= ahi * blo;
      abpp_r[2] <= alo * bhi;
      abpp_r[3] <= alo * blo;
      c2_3_r    <= len_r[2];
    end
  end

  always_ff @(posedge clk) begin
    logic [K_W-1:0] ksum;
    if (en) begin
      ksum = '0;
      for (int m = 0; m < 3; m++) begin
        ksum = ksum + K_W'({dpp_r[m][0], {(2*HALF_W){1'b0}}})
                    + K_W'({dpp_r[m][1], {(HALF_W+1){1'b0}}})
                    + K_W'(dpp_r[m][2]);
      end
      k4_r   <= ksum;
      p4_r   <= P_W'({abpp_r[0], {(2*HALF_W){1'b0}}})
              + P_W'({abpp_r[1], {HALF_W{1'b0}}})
              + P_W'({abpp_r[2], {HALF_W{1'b0}}})
              + P_W'(abpp_r[3]);
      c2_4_r <= c2_3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 2; j++) begin
          pp_r[i][j] <= SQ_W'(p4_r[i*HALF_W +: HALF_W]) * SQ_W'(c2_4_r[j*HALF_W +: HALF_W]);
        end
      end
      k5_r   <= k4_r;
      deg5_r <= (k4_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    logic [NUM_W-1:0] nsum;
    if (en) begin
      nsum = '0;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 2; j++) begin
          nsum = nsum + (NUM_W'(pp_r[i][j]) << (HALF_W * (i + j)));
        end
      end
      num6_r <= nsum;
      den6_r <= {k5_r, 2'b00};
      deg6_r <= deg5_r;
    end
  end

endmodule

/* rtl/tcr_queue.sv */
// Small FIFO of work items between the front and back pipelines.
// Depends on tcr_pkg.
`timescale 1ns / 1ps

module tcr_queue
  import tcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tcr_work_t in_work,
  output logic      out_valid,
  input  logic      out_ready,
  output tcr_work_t out_work
);

  tcr_work_t         mem [QUEUE_DEPTH];
  logic [QPTR_W:0]   wr_r, rd_r;
  logic              full, empty, push, pop;

  assign full      = (wr_r[QPTR_W] != rd_r[QPTR_W]) && (wr_r[QPTR_W-1:0] == rd_r[QPTR_W-1:0]);
  assign empty     = (wr_r == rd_r);
  assign in_ready  = !full;
  assign out_valid = !empty;
  assign push      = in_valid && !full;
  assign pop       = out_ready && !empty;
  assign out_work  = mem[rd_r[QPTR_W-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r[QPTR_W-1:0]] <= in_work;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
    end
  end

endmodule

/* rtl/tcr_back.sv */
// Back pipeline: saturation check, bit-per-stage restoring division of R^2 and
// bit-per-stage integer square root. Depends on tcr_pkg.
`timescale 1ns / 1ps

module tcr_back
  import tcr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcr_work_t        in_work,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [RAD_W-1:0] out_radius,
  output logic             out_degenerate,
  output logic             out_saturated
);

  localparam int WIDE_W = DEN_W + Q_W;

  logic                en;
  logic                sat_nxt;

  logic [NUM_W-1:0]    dv_rem_r [Q_W+1];
  logic [DEN_W-1:0]    dv_den_r [Q_W+1];
  logic [Q_W-1:0]      dv_quo_r [Q_W+1];
  logic                dv_deg_r [Q_W+1];
  logic                dv_sat_r [Q_W+1];
  logic [Q_W:0]        dv_vld_r;

  logic [Q_W-1:0]      sq_x_r   [RAD_W+1];
  logic [Q_W-1:0]      sq_res_r [RAD_W+1];
  logic                sq_deg_r [RAD_W+1];
  logic                sq_sat_r [RAD_W+1];
  logic [RAD_W:0]      sq_vld_r;

  logic                out_valid_r;
  logic [RAD_W-1:0]    radius_r;
  logic                deg_r, sat_r;

  assign en             = !(out_valid_r && !out_ready);
  assign in_ready       = en;
  assign out_valid      = out_valid_r;
  assign out_radius     = radius_r;
  assign out_degenerate = deg_r;
  assign out_saturated  = sat_r;

  // radius >= 2^36 exactly when num >= den * 2^72
  assign sat_nxt = !in_work.degenerate &&
                   ({{(WIDE_W-NUM_W){1'b0}}, in_work.num} >= {in_work.den, {Q_W{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r    <= '0;
      sq_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      dv_vld_r    <= {dv_vld_r[Q_W-1:0], in_valid};
      sq_vld_r    <= {sq_vld_r[RAD_W-1:0], dv_vld_r[Q_W]};
      out_valid_r <= sq_vld_r[RAD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= in_work.num;
      dv_den_r[0] <= in_work.den;
      dv_quo_r[0] <= '0;
      dv_deg_r[0] <= in_work.degenerate;
      dv_sat_r[0] <= sat_nxt;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    localparam int SH = Q_W - 1 - k;
    logic [WIDE_W-1:0] trial, rem_ext;
    logic              take;
    assign trial   = {{Q_W{1'b0}}, dv_den_r[k]} << SH;
    assign rem_ext = {{(WIDE_W-NUM_W){1'b0}}, dv_rem_r[k]};
    assign take    = (rem_ext >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[k+1] <= take ? NUM_W'(rem_ext - trial) : dv_rem_r[k];
        dv_den_r[k+1] <= dv_den_r[k];
        dv_quo_r[k+1] <= {dv_quo_r[k][Q_W-2:0], take};
        dv_deg_r[k+1] <= dv_deg_r[k];
        dv_sat_r[k+1] <= dv_sat_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r[0]   <= dv_quo_r[Q_W];
      sq_res_r[0] <= '0;
      sq_deg_r[0] <= dv_deg_r[Q_W];
      sq_sat_r[0] <= dv_sat_r[Q_W];
    end
  end

  // one root bit per stage
  for (genvar s = 0; s < RAD_W; s++) begin : g_sqrt
    localparam int BP = Q_W - 2 - 2 * s;
    logic [Q_W-1:0] bitv, trial;
    logic           take;
    assign bitv  = {{(Q_W-1){1'b0}}, 1'b1} << BP;
    assign trial = sq_res_r[s] + bitv;
    assign take  = (sq_x_r[s] >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        sq_x_r[s+1]   <= take ? (sq_x_r[s] - trial) : sq_x_r[s];
        sq_res_r[s+1] <= take ? ((sq_res_r[s] >> 1) + bitv) : (sq_res_r[s] >> 1);
        sq_deg_r[s+1] <= sq_deg_r[s];
        sq_sat_r[s+1] <= sq_sat_r[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r <= sq_deg_r[RAD_W];
      sat_r <= sq_sat_r[RAD_W];
      if (sq_deg_r[RAD_W]) begin
        radius_r <= '0;
      end else if (sq_sat_r[RAD_W]) begin
        radius_r <= '1;
      end else begin
        radius_r <= sq_res_r[RAD_W][RAD_W-1:0];
      end
    end
  end

endmodule
